[src/ttrk_pkg.sv]
package ttrk_pkg;

  localparam int NUM_IN_PTS  = 5;
  localparam int NUM_TRK_PTS = 4;
  localparam int IN_W        = 176;
  localparam int OUT_W       = 152;
  localparam int RES_W       = 147;

  localparam logic [7:0]  READY_BIT   = 8'h80;
  localparam logic [7:0]  RELEASE_MSK = 8'h8F;
  localparam logic [3:0]  MAX_TOUCHES = 4'd10;
  localparam logic [15:0] PT_RELEASED = 16'hFFFF;
  localparam logic [15:0] ST_PRESSED  = 16'h8000;
  localparam logic [15:0] ST_CAUGHT   = 16'h4000;
  localparam logic [15:0] ST_KEEP     = 16'hE000;
  localparam logic [7:0]  CNT_SAMPLE  = 8'd10;
  localparam logic [7:0]  CNT_MAX     = 8'd240;
  localparam logic [7:0]  CNT_RELOAD  = 8'd10;

  localparam logic [15:0] WIDTH_RST  = 16'd480;
  localparam logic [15:0] HEIGHT_RST = 16'd272;

  typedef enum logic {
    REG_SCREEN_WIDTH  = 1'b0,
    REG_SCREEN_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [15:0] y;
    logic [15:0] x;
  } point_t;

  typedef struct packed {
    point_t [NUM_IN_PTS-1:0] pts;
    logic [7:0]              idle_status;
    logic [7:0]              status_byte;
  } in_item_t;

  typedef struct packed {
    point_t [NUM_TRK_PTS-1:0] pts;
    logic                     sampled;
    logic                     clear_request;
    logic [15:0]              status_word;
    logic                     touch_found;
  } result_t;

  typedef struct packed {
    logic [7:0]               poll_count;
    logic [15:0]              touch_status;
    point_t [NUM_TRK_PTS-1:0] pts;
    point_t                   backup;
  } trk_state_t;

  // one bit per count value: set where the count is a multiple of ten
  function automatic logic [255:0] mult10_tab();
    logic [255:0] tab;
    int           k;
    tab = '0;
    k   = 0;
    for (int i = 0; i < 256; i++) begin
      tab[i] = (k == 0);
      k      = (k == 9) ? 0 : k + 1;
    end
    return tab;
  endfunction

  localparam logic [255:0] MULT10_TAB = mult10_tab();

endpackage

[src/ttrk_core.sv]
module ttrk_core #(
  parameter int MAX_POINTS = 5
) (
  input  ttrk_pkg::trk_state_t st,
  input  ttrk_pkg::in_item_t   item,
  input  logic [15:0]          screen_width,
  input  logic [15:0]          screen_height,
  output ttrk_pkg::trk_state_t st_nxt,
  output ttrk_pkg::result_t    res
);
  import ttrk_pkg::*;

  logic [7:0]  cnt;
  logic        sample;
  logic [7:0]  mode;
  logic [3:0]  n;
  logic        clear;
  logic        found;
  logic [15:0] mask;
  logic [15:0] ts;
  point_t [NUM_TRK_PTS-1:0] pts;

  always_comb begin
    cnt    = st.poll_count + 8'd1;
    sample = (cnt < CNT_SAMPLE) || MULT10_TAB[cnt];
    mode   = sample ? item.status_byte : item.idle_status;
    n      = mode[3:0];
    clear  = sample && mode[7] && (n <= MAX_TOUCHES);
    found  = sample && (n != 4'd0) && (n <= MAX_TOUCHES);
    mask   = ~(16'hFFFF << n);
    ts     = st.touch_status;
    pts    = st.pts;
    st_nxt = st;

    if (found) begin
      ts            = mask | ST_PRESSED | ST_CAUGHT;
      st_nxt.backup = st.pts[0];
      for (int i = 0; i < NUM_TRK_PTS; i++) begin
        if (i < MAX_POINTS && i < int'(n)) begin
          pts[i] = item.pts[i];
        end
      end
      if (pts[0].x > screen_width || pts[0].y > screen_height) begin
        if (n > 4'd1) begin
          pts[0] = pts[1];
          cnt    = 8'd0;
        end else begin
          // discard: fall back to the old point and status, then release
          pts[0] = st.pts[0];
          mode   = READY_BIT;
          ts     = st.touch_status;
        end
      end else begin
        cnt = 8'd0;
      end
    end

    if ((mode & RELEASE_MSK) == READY_BIT) begin
      if ((ts & ST_PRESSED) != 16'd0) begin
        ts = ts & ~ST_PRESSED;
      end else begin
        pts[0].x = PT_RELEASED;
        pts[0].y = PT_RELEASED;
        ts       = ts & ST_KEEP;
      end
    end

    if (cnt > CNT_MAX) begin
      cnt = CNT_RELOAD;
    end

    st_nxt.poll_count   = cnt;
    st_nxt.touch_status = ts;
    st_nxt.pts          = pts;

    res.touch_found   = found;
    res.status_word   = ts;
    res.clear_request = clear;
    res.sampled       = sample;
    res.pts           = pts;
  end

endmodule

[src/touch_point_tracker.sv]
// Pipeline: input register, then result register, between input request and result.
// Throughput: one poll per cycle while the output is not stalled; the poll counter,
//   status word and point registers update together, so polls follow back to back.
// Reset: synchronous active-low rst_n clears counter, status, points and valids;
//   screen size reloads to 480 x 272.
module touch_point_tracker #(
  parameter int MAX_POINTS = 5
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  // status_byte, idle_status, pt0_x, pt0_y, pt1_x, pt1_y, ... pt4_x, pt4_y
  input  logic [ttrk_pkg::IN_W-1:0]  in_tdata,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  // touch_found, status_word, clear_request, sampled, out0_x, out0_y, ... out3_y, zero pad
  output logic [ttrk_pkg::OUT_W-1:0] out_tdata,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  ttrk_pkg::cfg_reg_t         cfg_index,
  input  logic [15:0]                cfg_data
);
  import ttrk_pkg::*;

  logic        in_v_r;
  in_item_t    item_r;
  trk_state_t  st_r;
  trk_state_t  st_nxt;
  result_t     res;
  result_t     out_r;
  logic        out_v_r;
  logic [15:0] width_r;
  logic [15:0] height_r;
  logic        advance;

  assign advance   = !out_v_r || out_tready;
  assign in_tready = !in_v_r || advance;
  assign cfg_ready = 1'b1;

  ttrk_core #(
    .MAX_POINTS(MAX_POINTS)
  ) u_core (
    .st           (st_r),
    .item         (item_r),
    .screen_width (width_r),
    .screen_height(height_r),
    .st_nxt       (st_nxt),
    .res          (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_SCREEN_WIDTH:  width_r  <= cfg_data;
        REG_SCREEN_HEIGHT: height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tready) begin
      in_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready) begin
      item_r <= in_item_t'(in_tdata);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= '0;
      out_v_r <= 1'b0;
    end else if (in_v_r && advance) begin
      st_r    <= st_nxt;
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  // hold the result while the downstream stalls
  always_ff @(posedge clk) begin
    if (in_v_r && advance) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {{(OUT_W - RES_W){1'b0}}, out_r};

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.poll_count <= CNT_MAX)
    else $error("poll counter above reload limit");

  a_found_sampled: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && (out_r.touch_found || out_r.clear_request) |-> out_r.sampled)
    else $error("touch or clear request on a poll that did not sample");

  a_mask_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> out_r.status_word[13:10] == 4'd0)
    else $error("status word carries bits outside flags and mask");

  a_stall_only: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> in_v_r && out_v_r && !out_tready)
    else $error("input stalled without a downstream stall");

endmodule
